// ----- design/tce_pkg.sv -----
// ----------------------------------------------------------------------------
// tce_pkg
// shared types, opcodes, status codes and reset values of the execute unit
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int TCE_MEM_BYTES = 65536;
    localparam int WORD_BYTES    = 4;
    localparam int DIV_STEPS     = 32;

    // instruction opcodes
    localparam logic [4:0] CMD_HLT      = 5'd0;
    localparam logic [4:0] CMD_PUSH_IMM = 5'd1;
    localparam logic [4:0] CMD_PUSH_REG = 5'd2;
    localparam logic [4:0] CMD_POP      = 5'd3;
    localparam logic [4:0] CMD_MOV_IMM  = 5'd4;
    localparam logic [4:0] CMD_MOV_REG  = 5'd5;
    localparam logic [4:0] CMD_ADD_IMM  = 5'd6;
    localparam logic [4:0] CMD_ADD_REG  = 5'd7;
    localparam logic [4:0] CMD_MUL_IMM  = 5'd8;
    localparam logic [4:0] CMD_MUL_REG  = 5'd9;
    localparam logic [4:0] CMD_DIV_IMM  = 5'd10;
    localparam logic [4:0] CMD_DIV_REG  = 5'd11;
    localparam logic [4:0] CMD_MOD_IMM  = 5'd12;
    localparam logic [4:0] CMD_MOD_REG  = 5'd13;
    localparam logic [4:0] CMD_LOG      = 5'd14;
    localparam logic [4:0] CMD_NEG      = 5'd15;
    localparam logic [4:0] CMD_CMP_REG  = 5'd16;
    localparam logic [4:0] CMD_CMP_IMM  = 5'd17;
    localparam logic [4:0] CMD_LOAD     = 5'd18;
    localparam logic [4:0] CMD_STORE    = 5'd19;

    // result status codes
    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_UNDER   = 3'd1;
    localparam logic [2:0] STS_OVER    = 3'd2;
    localparam logic [2:0] STS_BADREG  = 3'd3;
    localparam logic [2:0] STS_DIVZERO = 3'd4;
    localparam logic [2:0] STS_SEGV    = 3'd5;

    // register numbers
    localparam logic [2:0] REG_SP   = 3'd5;
    localparam int         GP_REGS  = 5;

    // configuration register indexes
    localparam logic [1:0] CFG_STACK_TOP    = 2'd0;
    localparam logic [1:0] CFG_STACK_BOTTOM = 2'd1;
    localparam logic [1:0] CFG_DATA_MIN     = 2'd2;
    localparam logic [1:0] CFG_DATA_MAX     = 2'd3;

    localparam logic [15:0] RST_STACK_TOP    = 16'd65535;
    localparam logic [15:0] RST_STACK_BOTTOM = 16'd32768;
    localparam logic [15:0] RST_DATA_MIN     = 16'd0;
    localparam logic [15:0] RST_DATA_MAX     = 16'd32764;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_HLT,
        OP_PUSH,
        OP_POP,
        OP_MOV,
        OP_ADD,
        OP_MUL,
        OP_DIV,
        OP_LOG,
        OP_NEG,
        OP_CMP,
        OP_LOAD,
        OP_STORE
    } op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_MUL,
        S_DIVSET,
        S_DIV,
        S_MEMRD,
        S_MEMWR,
        S_COMMIT,
        S_RESULT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_step;
        logic take;
        logic src_sel;
        logic fetch;
        logic decode;
        logic mul_load;
        logic div_init;
        logic div_step;
        logic rd_step;
        logic wr_step;
        logic commit;
        logic out_load;
    } ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic in_valid;
        op_t  op;
        logic err;
        logic div_last;
        logic rd_last;
        logic wr_last;
        logic out_busy;
    } sts_t;

endpackage

// ----- design/tce_if.sv -----
// ----------------------------------------------------------------------------
// tce_in_if / tce_out_if
// valid/ready channels carrying instructions and results
// ----------------------------------------------------------------------------
interface tce_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  cmd;
    logic [2:0]  dst_index;
    logic [2:0]  src_index;
    logic [31:0] imm;
    logic [15:0] address;

    modport source (output valid, cmd, dst_index, src_index, imm, address, input ready);
    modport sink (input valid, cmd, dst_index, src_index, imm, address, output ready);
endinterface

interface tce_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] value;
    logic        running;
    logic        flag_valid;
    logic        equal;
    logic        less;
    logic        greater;

    modport source (output valid, status, value, running, flag_valid, equal, less, greater,
                    input ready);
    modport sink (input valid, status, value, running, flag_valid, equal, less, greater,
                  output ready);
endinterface

// ----- design/tce_ram.sv -----
// ----------------------------------------------------------------------------
// tce_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/tce_datapath.sv -----
// ----------------------------------------------------------------------------
// tce_datapath
// register file, stack pointer, flags, divider, memory sequencing, result reg
// ----------------------------------------------------------------------------
module tce_datapath #(
    parameter int MEM_BYTES = tce_pkg::TCE_MEM_BYTES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tce_pkg::ctl_t                ctl,
    output tce_pkg::sts_t                sts,
    tce_in_if.sink                       in_ch,
    tce_out_if.source                    out_ch,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [15:0]                  cfg_wdata,
    output logic                         mem_we,
    output logic [$clog2(MEM_BYTES)-1:0] mem_waddr,
    output logic [7:0]                   mem_wdata,
    output logic [$clog2(MEM_BYTES)-1:0] mem_raddr,
    input  logic [7:0]                   mem_rdata
);
    import tce_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    // architectural state
    logic [31:0] rf_reg [0:GP_REGS-1];
    logic [15:0] sp_reg;
    logic        run_reg;
    logic        fv_reg, eq_reg, lt_reg, gt_reg;
    logic [15:0] top_reg, bottom_reg, dmin_reg, dmax_reg;

    // control counters
    logic [AW-1:0] clr_cnt_reg;
    logic [4:0]    cnt_reg;
    logic          out_valid_reg;

    // item and work registers
    logic [4:0]  cmd_reg;
    logic [2:0]  d_reg, s_reg;
    logic [31:0] imm_reg;
    logic [15:0] addr_reg;
    logic [31:0] a_reg, b_reg, prod_reg;
    logic [2:0]  st_reg;
    logic [31:0] rem_reg, quo_reg, den_reg;
    logic [31:0] word_reg;
    logic [2:0]  o_status_reg;
    logic [31:0] o_value_reg;
    logic        o_running_reg, o_fv_reg, o_eq_reg, o_lt_reg, o_gt_reg;

    // decode
    op_t         op;
    logic        dok, sok, isreg, segv, b_from_reg;
    logic [2:0]  st_code;
    logic [2:0]  rd_idx;
    logic [31:0] rd_val;
    logic [32:0] div_try;
    logic [31:0] wb_val;
    logic [31:0] q_fix, r_fix;
    logic [15:0] rbase, wbase, rsum, wsum;
    logic [31:0] wr_word;

    always_comb
    begin
        case (cmd_reg) inside
            CMD_HLT:                                         op = OP_HLT;
            CMD_PUSH_IMM, CMD_PUSH_REG:                      op = OP_PUSH;
            CMD_POP:                                         op = OP_POP;
            CMD_MOV_IMM, CMD_MOV_REG:                        op = OP_MOV;
            CMD_ADD_IMM, CMD_ADD_REG:                        op = OP_ADD;
            CMD_MUL_IMM, CMD_MUL_REG:                        op = OP_MUL;
            CMD_DIV_IMM, CMD_DIV_REG, CMD_MOD_IMM, CMD_MOD_REG: op = OP_DIV;
            CMD_LOG:                                         op = OP_LOG;
            CMD_NEG:                                         op = OP_NEG;
            CMD_CMP_REG, CMD_CMP_IMM:                        op = OP_CMP;
            CMD_LOAD:                                        op = OP_LOAD;
            CMD_STORE:                                       op = OP_STORE;
            default:                                         op = OP_NOP;
        endcase
    end

    assign dok        = (d_reg <= REG_SP);
    assign sok        = (s_reg <= REG_SP);
    assign isreg      = cmd_reg[0];
    assign segv       = (addr_reg > dmax_reg) || (addr_reg < dmin_reg);
    assign b_from_reg = ((op == OP_MOV || op == OP_ADD || op == OP_MUL || op == OP_DIV) && isreg)
                        || (cmd_reg == CMD_CMP_REG);

    // error check in the order the instruction set defines
    always_comb
    begin
        st_code = STS_OK;
        unique case (op)
            OP_PUSH:
            begin
                if (sp_reg <= bottom_reg)
                    st_code = STS_OVER;
                else if (cmd_reg == CMD_PUSH_REG && !dok)
                    st_code = STS_BADREG;
            end
            OP_POP:
            begin
                if (sp_reg == top_reg)
                    st_code = STS_UNDER;
                else if (!dok)
                    st_code = STS_BADREG;
            end
            OP_MOV, OP_ADD, OP_MUL:
            begin
                if (!dok || (isreg && !sok))
                    st_code = STS_BADREG;
            end
            OP_DIV:
            begin
                if (!dok || (isreg && !sok))
                    st_code = STS_BADREG;
                else if (b_reg == 32'd0)
                    st_code = STS_DIVZERO;
            end
            OP_LOG, OP_NEG:
            begin
                if (!dok)
                    st_code = STS_BADREG;
            end
            OP_CMP:
            begin
                if (!dok || (cmd_reg == CMD_CMP_REG && !sok))
                    st_code = STS_BADREG;
            end
            OP_LOAD:
            begin
                if (segv)
                    st_code = STS_SEGV;
                else if (!dok)
                    st_code = STS_BADREG;
            end
            OP_STORE:
            begin
                if (!dok)
                    st_code = STS_BADREG;
                else if (segv)
                    st_code = STS_SEGV;
            end
            OP_NOP, OP_HLT:
            begin
                st_code = STS_OK;
            end
            default:
            begin
                st_code = STS_OK;
            end
        endcase
    end

    // single register read port
    assign rd_idx = ctl.src_sel ? s_reg : d_reg;
    always_comb
    begin
        if (rd_idx < REG_SP)
            rd_val = rf_reg[rd_idx];
        else if (rd_idx == REG_SP)
            rd_val = {16'd0, sp_reg};
        else
            rd_val = 32'd0;
    end

    // divider step and sign fix
    assign div_try = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
    assign q_fix   = (a_reg[31] != b_reg[31]) ? (32'd0 - quo_reg) : quo_reg;
    assign r_fix   = a_reg[31] ? (32'd0 - rem_reg) : rem_reg;

    always_comb
    begin
        unique case (op)
            OP_MOV:            wb_val = b_reg;
            OP_ADD:            wb_val = a_reg + b_reg;
            OP_MUL:            wb_val = prod_reg;
            OP_DIV:            wb_val = (cmd_reg >= CMD_MOD_IMM) ? r_fix : q_fix;
            OP_NEG:            wb_val = 32'd0 - a_reg;
            OP_LOAD, OP_POP:   wb_val = word_reg;
            default:           wb_val = a_reg;
        endcase
    end

    // byte addresses
    assign rbase   = (op == OP_POP) ? sp_reg : addr_reg;
    assign wbase   = (op == OP_PUSH) ? (sp_reg - 16'(WORD_BYTES)) : addr_reg;
    assign rsum    = rbase + 16'(cnt_reg[1:0]);
    assign wsum    = wbase + 16'(cnt_reg[1:0]);
    assign wr_word = (cmd_reg == CMD_PUSH_IMM) ? imm_reg : a_reg;

    always_comb
    begin
        mem_we    = ctl.clr_step || ctl.wr_step;
        mem_waddr = ctl.clr_step ? clr_cnt_reg : wsum[AW-1:0];
        mem_wdata = ctl.clr_step ? 8'd0 : wr_word[{cnt_reg[1:0], 3'b000} +: 8];
        mem_raddr = rsum[AW-1:0];
    end

    // status to controller
    always_comb
    begin
        sts.clr_last = &clr_cnt_reg;
        sts.in_valid = in_ch.valid;
        sts.op       = op;
        sts.err      = (st_code != STS_OK);
        sts.div_last = (cnt_reg == 5'(DIV_STEPS - 1));
        sts.rd_last  = (cnt_reg == 5'(WORD_BYTES));
        sts.wr_last  = (cnt_reg == 5'(WORD_BYTES - 1));
        sts.out_busy = out_valid_reg && !out_ch.ready;
    end

    assign in_ch.ready = ctl.take;

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GP_REGS; i++)
                rf_reg[i] <= 32'd0;
            sp_reg        <= RST_STACK_TOP;
            run_reg       <= 1'b1;
            fv_reg        <= 1'b0;
            eq_reg        <= 1'b0;
            lt_reg        <= 1'b0;
            gt_reg        <= 1'b0;
            top_reg       <= RST_STACK_TOP;
            bottom_reg    <= RST_STACK_BOTTOM;
            dmin_reg      <= RST_DATA_MIN;
            dmax_reg      <= RST_DATA_MAX;
            clr_cnt_reg   <= '0;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_STACK_TOP:    top_reg    <= cfg_wdata;
                    CFG_STACK_BOTTOM: bottom_reg <= cfg_wdata;
                    CFG_DATA_MIN:     dmin_reg   <= cfg_wdata;
                    CFG_DATA_MAX:     dmax_reg   <= cfg_wdata;
                    default:          top_reg    <= top_reg;
                endcase
            end

            if (ctl.clr_step)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;

            if (ctl.decode || ctl.div_init)
                cnt_reg <= 5'd0;
            else if (ctl.div_step || ctl.rd_step || ctl.wr_step)
                cnt_reg <= cnt_reg + 5'd1;

            if (ctl.commit && st_reg == STS_OK)
            begin
                unique case (op)
                    OP_HLT:
                    begin
                        run_reg <= 1'b0;
                    end
                    OP_PUSH:
                    begin
                        sp_reg <= sp_reg - 16'(WORD_BYTES);
                    end
                    OP_POP:
                    begin
                        if (d_reg == REG_SP)
                            sp_reg <= wb_val[15:0];
                        else
                        begin
                            sp_reg <= sp_reg + 16'(WORD_BYTES);
                            rf_reg[d_reg] <= wb_val;
                        end
                    end
                    OP_MOV, OP_ADD, OP_MUL, OP_DIV, OP_NEG, OP_LOAD:
                    begin
                        if (d_reg == REG_SP)
                            sp_reg <= wb_val[15:0];
                        else
                            rf_reg[d_reg] <= wb_val;
                    end
                    OP_CMP:
                    begin
                        fv_reg <= 1'b1;
                        eq_reg <= (a_reg == b_reg);
                        lt_reg <= ($signed(a_reg) < $signed(b_reg));
                        gt_reg <= ($signed(a_reg) > $signed(b_reg));
                    end
                    default:
                    begin
                        run_reg <= run_reg;
                    end
                endcase
            end

            if (ctl.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.take && in_ch.valid)
        begin
            cmd_reg  <= in_ch.cmd;
            d_reg    <= in_ch.dst_index;
            s_reg    <= in_ch.src_index;
            imm_reg  <= in_ch.imm;
            addr_reg <= in_ch.address;
        end
        if (ctl.fetch)
            b_reg <= b_from_reg ? rd_val : imm_reg;
        if (ctl.decode)
        begin
            a_reg  <= rd_val;
            st_reg <= st_code;
        end
        if (ctl.mul_load)
            prod_reg <= a_reg * b_reg;
        if (ctl.div_init)
        begin
            rem_reg <= 32'd0;
            quo_reg <= a_reg[31] ? (32'd0 - a_reg) : a_reg;
            den_reg <= b_reg[31] ? (32'd0 - b_reg) : b_reg;
        end
        else if (ctl.div_step)
        begin
            if (!div_try[32])
            begin
                rem_reg <= div_try[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (ctl.rd_step && cnt_reg != 5'd0)
            word_reg <= {mem_rdata, word_reg[31:8]};
        // run and compare flags are captured with the result so a later
        // instruction cannot change them while the result waits
        if (ctl.out_load)
        begin
            o_status_reg  <= st_reg;
            o_value_reg   <= rd_val;
            o_running_reg <= run_reg;
            o_fv_reg      <= fv_reg;
            o_eq_reg      <= eq_reg;
            o_lt_reg      <= lt_reg;
            o_gt_reg      <= gt_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = o_status_reg;
    assign out_ch.value      = o_value_reg;
    assign out_ch.running    = o_running_reg;
    assign out_ch.flag_valid = o_fv_reg;
    assign out_ch.equal      = o_eq_reg;
    assign out_ch.less       = o_lt_reg;
    assign out_ch.greater    = o_gt_reg;

endmodule

// ----- design/tce_ctrl.sv -----
// ----------------------------------------------------------------------------
// tce_ctrl
// instruction sequencer of the execute unit
// ----------------------------------------------------------------------------
module tce_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  tce_pkg::sts_t sts,
    output tce_pkg::ctl_t ctl
);
    import tce_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                ctl.take = 1'b1;
                if (sts.in_valid)
                    state_next = S_FETCH;
            end
            S_FETCH:
            begin
                ctl.src_sel = 1'b1;
                ctl.fetch   = 1'b1;
                state_next  = S_DECODE;
            end
            S_DECODE:
            begin
                ctl.decode = 1'b1;
                if (sts.err)
                    state_next = S_COMMIT;
                else
                begin
                    unique case (sts.op)
                        OP_MUL:            state_next = S_MUL;
                        OP_DIV:            state_next = S_DIVSET;
                        OP_POP, OP_LOAD:   state_next = S_MEMRD;
                        OP_PUSH, OP_STORE: state_next = S_MEMWR;
                        default:           state_next = S_COMMIT;
                    endcase
                end
            end
            S_MUL:
            begin
                ctl.mul_load = 1'b1;
                state_next   = S_COMMIT;
            end
            S_DIVSET:
            begin
                ctl.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_COMMIT;
            end
            S_MEMRD:
            begin
                ctl.rd_step = 1'b1;
                if (sts.rd_last)
                    state_next = S_COMMIT;
            end
            S_MEMWR:
            begin
                ctl.wr_step = 1'b1;
                if (sts.wr_last)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                ctl.commit = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/toy_cpu_execute_unit_top.sv -----
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit_top
// one instruction per transfer over a small register machine with byte memory
// ----------------------------------------------------------------------------
// after reset the unit first zeroes its data memory, one byte per cycle, and
// takes no instruction until that is done (configuration writes are taken
// meanwhile). MEM_BYTES must be a power of two. each instruction then runs one
// at a time through the sequencer: accept, register fetch, decode/check, then
// commit and result load; simple and failing instructions go from decode
// straight to commit. mul adds one registered 32x32 multiply, store and push
// write and load and pop read a word byte by byte (the single byte-wide memory
// port moves one byte per cycle), div and mod add the 32 steps of the shared
// radix-2 divider. a finished result sits in the output register until its
// transfer, while the next instruction is already accepted and worked on
module toy_cpu_execute_unit_top #(
    parameter int MEM_BYTES = tce_pkg::TCE_MEM_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    tce_in_if.sink      in_ch,
    tce_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import tce_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    // command and status between sequencer and datapath
    ctl_t ctl;
    sts_t sts;

    // data memory port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    tce_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    tce_datapath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // byte-wide data memory, little-endian words are built a byte at a time
    tce_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ----- design/tce_checker.sv -----
// ----------------------------------------------------------------------------
// tce_checker
// port-level checks of the execute unit, bound to the top level
// ----------------------------------------------------------------------------
module tce_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic       flag_valid,
    input logic       equal,
    input logic       less,
    input logic       greater
);
    import tce_pkg::*;

    // instructions accepted whose result has not been transferred
    logic [1:0] pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'd0;
        else
            pend_reg <= pend_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without an accepted instruction");

    a_flags_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flag_valid |-> $onehot({equal, less, greater}))
        else $error("compare flags not exclusive");

    a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !flag_valid |-> !(equal || less || greater))
        else $error("compare flags set before any compare");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= STS_SEGV)
        else $error("status code out of range");

endmodule

bind toy_cpu_execute_unit_top tce_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .status     (out_ch.status),
    .flag_valid (out_ch.flag_valid),
    .equal      (out_ch.equal),
    .less       (out_ch.less),
    .greater    (out_ch.greater)
);
